FILE: rtl/dnl_pkg.sv
// Package for the day/night lightmap pixel core.
// Q16 fixed-point types, constants and the level lookup tables.
// No dependencies.
package dnl_pkg;

  typedef logic [16:0] qv_t;        // Q16 fraction, 0..1 inclusive
  typedef qv_t q_tab_t [16];        // one entry per light level

  localparam qv_t Q_ONE = 17'd65536;
  localparam logic [15:0] C_0P6 = 16'd39322;
  localparam logic [15:0] C_0P4 = 16'd26214;
  localparam logic [15:0] C_0P9 = 16'd58982;
  localparam logic [16:0] C_1P1 = 17'd72090;
  localparam logic [15:0] C_0P96 = 16'd62915;
  localparam logic [15:0] C_GREY = 16'd1966;
  localparam logic [15:0] C_AMBIENT = 16'd9830;

  // pipeline depth: 5 position stages, 2 sky/level stages, 4 shade stages
  localparam int unsigned POS_LAT = 5;
  localparam int unsigned NSTG = 11;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 16;
  endfunction

  // level L -> L/15 in Q16, rounded down
  function automatic q_tab_t mk_lvl_tab();
    q_tab_t t;
    logic [63:0] v;
    for (int i = 0; i < 16; i++) begin
      v = (64'(i) * 64'd65536) / 64'd15;
      t[i] = v[16:0];
    end
    return t;
  endfunction

  // green block polynomial: b*((b*0.6+0.4)*0.6+0.4)
  function automatic q_tab_t mk_bg_tab();
    q_tab_t t;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    for (int i = 0; i < 16; i++) begin
      b = (64'(i) * 64'd65536) / 64'd15;
      x = qmul(b, 64'(C_0P6)) + 64'(C_0P4);
      y = qmul(x, 64'(C_0P6)) + 64'(C_0P4);
      x = qmul(b, y);
      t[i] = x[16:0];
    end
    return t;
  endfunction

  // blue block polynomial: b*(b*b*0.6+0.4)
  function automatic q_tab_t mk_bb_tab();
    q_tab_t t;
    logic [63:0] b;
    logic [63:0] x;
    for (int i = 0; i < 16; i++) begin
      b = (64'(i) * 64'd65536) / 64'd15;
      x = qmul(qmul(b, b), 64'(C_0P6)) + 64'(C_0P4);
      x = qmul(b, x);
      t[i] = x[16:0];
    end
    return t;
  endfunction

  localparam q_tab_t LVL_TAB = mk_lvl_tab();
  localparam q_tab_t BG_TAB = mk_bg_tab();
  localparam q_tab_t BB_TAB = mk_bb_tab();

endpackage

FILE: rtl/dnl_if.sv
// Valid/ready channel interfaces for the lightmap pixel core.
// Request channel and pixel result channel; no dependencies.
interface dnl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] day_time;
  logic        [3:0]  sky_level;
  logic        [3:0]  block_level;

  modport source (output valid, output day_time, output sky_level, output block_level,
                  input ready);
  modport sink (input valid, input day_time, input sky_level, input block_level,
                output ready);
endinterface

interface dnl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/dnl_pos.sv
// Day position and sky brightness pipeline, five register stages.
// Uses dnl_pkg for the Q16 type and constants.
module dnl_pos import dnl_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] day_time,
  output qv_t                bright
);

  localparam logic [1:0] SEG_DAY   = 2'd0;
  localparam logic [1:0] SEG_DUSK  = 2'd1;
  localparam logic [1:0] SEG_NIGHT = 2'd2;
  localparam logic [1:0] SEG_DAWN  = 2'd3;

  localparam logic [26:0] RCP_375 = 27'd91625968;  // floor(2^35/375)
  localparam logic [17:0] RCP_125 = 18'd134218;    // ceil(2^24/125)

  // stage 1: t = 64*q + lo, q biased by 2^25 so it is unsigned
  logic [25:0] u_nxt;
  logic [52:0] prod_nxt;
  logic [52:0] prod_r;
  logic [25:0] u_r;
  logic [5:0]  lo1_r;

  assign u_nxt    = {~day_time[31], day_time[30:6]};
  assign prod_nxt = 53'(u_nxt) * 53'(RCP_375);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      u_r    <= u_nxt;
      lo1_r  <= day_time[5:0];
    end
  end

  // stage 2: remainder estimate, 0..749
  logic [17:0] qd;
  logic [26:0] qm;
  logic [26:0] rem_full;
  logic [9:0]  r0_nxt;
  logic [9:0]  r0_r;
  logic [5:0]  lo2_r;

  assign qd       = prod_r[52:35];
  assign qm       = 27'(qd) * 27'd375;
  assign rem_full = 27'(u_r) - qm;
  assign r0_nxt   = rem_full[9:0];

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r  <= r0_nxt;
      lo2_r <= lo1_r;
    end
  end

  // stage 3: final remainder, then undo the 2^25 bias (2^25 mod 375 = 182)
  logic [9:0]  r1;
  logic [8:0]  r2;
  logic [14:0] p_nxt;
  logic [14:0] p_r;

  always_comb begin
    r1 = (r0_r >= 10'd375) ? r0_r - 10'd375 : r0_r;
    r2 = (r1 >= 10'd182) ? 9'(r1 - 10'd182) : 9'(r1 + 10'd193);
    p_nxt = {r2, lo2_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  // stage 4: segment of the day and offset into the ramp
  logic [1:0]  seg_nxt;
  logic [9:0]  d_nxt;
  logic [16:0] z_nxt;
  logic [1:0]  seg_r;
  logic [9:0]  d_r;
  logic [16:0] z_r;

  always_comb begin
    d_nxt = '0;
    priority if (p_r < 15'd12000) begin
      seg_nxt = SEG_DAY;
    end else if (p_r < 15'd13000) begin
      seg_nxt = SEG_DUSK;
      d_nxt   = 10'(p_r - 15'd12000);
    end else if (p_r < 15'd23000) begin
      seg_nxt = SEG_NIGHT;
    end else begin
      seg_nxt = SEG_DAWN;
      d_nxt   = 10'(p_r - 15'd23000);
    end
    z_nxt = 17'(d_nxt) * 17'd67;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
      d_r   <= d_nxt;
      z_r   <= z_nxt;
    end
  end

  // stage 5: d*65536/1000 = d*65 + d*67/125
  logic [34:0] zq;
  logic [15:0] frac;
  qv_t         bright_nxt;
  qv_t         bright_r;

  always_comb begin
    zq   = 35'(z_r) * 35'(RCP_125);
    frac = 16'(d_r) * 16'd65 + 16'(zq[33:24]);
    unique case (seg_r)
      SEG_DAY:   bright_nxt = Q_ONE;
      SEG_DUSK:  bright_nxt = Q_ONE - 17'(frac);
      SEG_NIGHT: bright_nxt = '0;
      SEG_DAWN:  bright_nxt = 17'(frac);
      default:   bright_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bright_r <= bright_nxt;
    end
  end

  assign bright = bright_r;

endmodule

FILE: rtl/dnl_shade.sv
// One color channel of the pixel: saturate, grey mix, quartic curve, byte.
// Four register stages; uses dnl_pkg for the Q16 type and constants.
module dnl_shade import dnl_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  qv_t        blk,
  input  qv_t        sky,
  output logic [7:0] px_byte
);

  // stage 1: t = sat(blk + sky), scaled by 0.96
  logic [17:0] sum1;
  qv_t         t1;
  logic [32:0] m_prod;
  qv_t         m_r;

  always_comb begin
    sum1   = 18'(blk) + 18'(sky);
    t1     = (sum1 > 18'(Q_ONE)) ? Q_ONE : sum1[16:0];
    m_prod = 33'(t1) * 33'(C_0P96);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_prod[32:16];
    end
  end

  // stage 2: add grey, u = 1 - t, u^2
  logic [17:0] sum2;
  qv_t         t2;
  qv_t         u;
  logic [33:0] uu_prod;
  qv_t         t2_r;
  qv_t         uu_r;

  always_comb begin
    sum2    = 18'(m_r) + 18'(C_GREY);
    t2      = (sum2 > 18'(Q_ONE)) ? Q_ONE : sum2[16:0];
    u       = Q_ONE - t2;
    uu_prod = 34'(u) * 34'(u);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r <= t2;
      uu_r <= uu_prod[32:16];
    end
  end

  // stage 3: u^4
  logic [33:0] u4_prod;
  qv_t         t3_r;
  qv_t         u4_r;

  assign u4_prod = 34'(uu_r) * 34'(uu_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r <= t2_r;
      u4_r <= u4_prod[32:16];
    end
  end

  // stage 4: half blend with 1 - u^4, ambient floor, to byte
  qv_t         ng;
  logic [17:0] vs;
  qv_t         v;
  logic [24:0] vb;
  logic [7:0]  byte_r;

  always_comb begin
    ng = Q_ONE - u4_r;
    vs = 18'(t3_r) + 18'(ng);
    v  = vs[17:1];
    if (v > Q_ONE) begin
      v = Q_ONE;
    end
    if (v < 17'(C_AMBIENT)) begin
      v = 17'(C_AMBIENT);
    end
    vb = (25'(v) << 8) - 25'(v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= vb[23:16];
    end
  end

  assign px_byte = byte_r;

endmodule

FILE: rtl/day_night_lightmap_pixel_core.sv
// Day/night lightmap pixel core: top level with level tables and sky scaling.
// Depends on dnl_pkg, dnl_if, dnl_pos and dnl_shade.
//
// Takes one pixel request (day time, sky level, block level) per clock and
// presents one RGB pixel on out_px once the request has passed all stages. The
// datapath is a single 11-stage pipeline: five stages reduce the day time
// modulo 24000 and form the sky brightness, two scale the sky and block light,
// and four shade each channel. The whole pipeline holds when the result is not
// taken, so the throughput is one pixel per clock while out_px.ready stays
// high. There is no configuration and no state beyond the pipeline itself.
module day_night_lightmap_pixel_core import dnl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  dnl_in_if.sink   in_px,
  dnl_out_if.source out_px
);

  typedef struct packed {
    logic [3:0] sky;
    logic [3:0] blk;
  } lvl_t;

  logic            pipe_en;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  assign pipe_en      = !vld_r[NSTG-1] || out_px.ready;
  assign in_px.ready  = pipe_en;
  assign vld_nxt      = {vld_r[NSTG-2:0], in_px.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  // sky brightness, stages 1..5
  qv_t bright;

  dnl_pos u_pos (
    .clk      (clk),
    .en       (pipe_en),
    .day_time (in_px.day_time),
    .bright   (bright)
  );

  // levels ride alongside the position pipeline
  lvl_t lvl_r [POS_LAT];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lvl_r[0] <= '{sky: in_px.sky_level, blk: in_px.block_level};
      for (int i = 1; i < POS_LAT; i++) begin
        lvl_r[i] <= lvl_r[i-1];
      end
    end
  end

  // stage 6: sky light times brightness
  logic [33:0] s_prod;
  qv_t         s_r;
  logic [3:0]  blk6_r;

  assign s_prod = 34'(LVL_TAB[lvl_r[POS_LAT-1].sky]) * 34'(bright);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_r    <= s_prod[32:16];
      blk6_r <= lvl_r[POS_LAT-1].blk;
    end
  end

  // stage 7: cool sky tint and warm block colors
  logic [32:0] sr_prod;
  logic [33:0] sb_prod;
  qv_t         sr_r;
  qv_t         sg_r;
  qv_t         sb_r;
  qv_t         br_r;
  qv_t         bg_r;
  qv_t         bb_r;

  assign sr_prod = 33'(s_r) * 33'(C_0P9);
  assign sb_prod = 34'(s_r) * 34'(C_1P1);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sr_r <= sr_prod[32:16];
      sg_r <= s_r;
      sb_r <= sb_prod[32:16];
      br_r <= LVL_TAB[blk6_r];
      bg_r <= BG_TAB[blk6_r];
      bb_r <= BB_TAB[blk6_r];
    end
  end

  // stages 8..11: per-channel shading
  dnl_shade u_shade_r (
    .clk     (clk),
    .en      (pipe_en),
    .blk     (br_r),
    .sky     (sr_r),
    .px_byte (out_px.red)
  );

  dnl_shade u_shade_g (
    .clk     (clk),
    .en      (pipe_en),
    .blk     (bg_r),
    .sky     (sg_r),
    .px_byte (out_px.green)
  );

  dnl_shade u_shade_b (
    .clk     (clk),
    .en      (pipe_en),
    .blk     (bb_r),
    .sky     (sb_r),
    .px_byte (out_px.blue)
  );

  assign out_px.valid = vld_r[NSTG-1];

endmodule
